[sv/gatb_pkg.sv]
// ----------------------------------------------------------------------------
// gatb_pkg
// Shared types and constants of the tournament breeder: field widths, command
// codes, sequencer states and the request bundle to the population store.
// ----------------------------------------------------------------------------
package gatb_pkg;

    localparam int SLOT_W   = 8;
    localparam int RATING_W = 32;
    localparam int CHR_W    = 64;
    localparam int DRAWS_W  = 24;
    localparam int POS_W    = 6;
    localparam int MODE_W   = 2;

    localparam int NUM_SLOTS_DEF  = 256;
    localparam int GENE_BITS_DEF  = 64;
    localparam int TOURNAMENT_DEF = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_BREED = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_WR,
        ST_LD_A1,
        ST_LD_C1,
        ST_LD_C2,
        ST_RD,
        ST_RD_C,
        ST_BR_ISS,
        ST_BR_CMP,
        ST_BR_CHA,
        ST_BR_CHB,
        ST_FIN_A,
        ST_FIN_C,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                      wr_en;
        logic [SLOT_W-1:0]         wr_addr;
        logic signed [RATING_W-1:0] wr_rating;
        logic [SLOT_W-1:0]         chr_rd_addr;
        logic [SLOT_W-1:0]         rat_rd_addr;
    } store_req_t;

endpackage

[sv/ga_tournament_breeder_core.sv]
// ----------------------------------------------------------------------------
// ga_tournament_breeder_core
// Breeding unit for a genetic algorithm with tournament selection.
// ----------------------------------------------------------------------------
// Input channel s_*: one item is a command. Load writes a chromosome and its
// signed rating into a population slot and updates the two-slot elite list;
// read returns a stored chromosome; breed runs two tournaments over the
// supplied draws, then crossover and mutation on the two winners.
// Result channel m_*: exactly one item per command, carrying the children,
// the winners and the elite list with the best rating.
// Timing: s_ready is high only while the sequencer is idle, so a new command is
// taken only once the result of the last one has been registered. The pace is
// set by the single registered read port of each store memory, walked once per
// tournament draw. The result register holds the item while m_ready is low; a
// finished item then waits in the sequencer until the register frees up.
// Reset clears the sequencer, the output valid and the elite list to slot 0;
// the store memories are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module ga_tournament_breeder_core #(
    parameter int NUM_SLOTS  = gatb_pkg::NUM_SLOTS_DEF,
    parameter int GENE_BITS  = gatb_pkg::GENE_BITS_DEF,
    parameter int TOURNAMENT = gatb_pkg::TOURNAMENT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [gatb_pkg::MODE_W-1:0]            s_mode,
    input  logic [gatb_pkg::SLOT_W-1:0]            s_slot,
    input  logic [gatb_pkg::CHR_W-1:0]             s_chromosome,
    input  logic signed [gatb_pkg::RATING_W-1:0]   s_rating,
    input  logic [gatb_pkg::DRAWS_W-1:0]           s_draws_a,
    input  logic [gatb_pkg::DRAWS_W-1:0]           s_draws_b,
    input  logic                                   s_do_cross,
    input  logic [gatb_pkg::POS_W-1:0]             s_cross_point,
    input  logic                                   s_mutate_a,
    input  logic [gatb_pkg::POS_W-1:0]             s_mutate_a_pos,
    input  logic                                   s_mutate_b,
    input  logic [gatb_pkg::POS_W-1:0]             s_mutate_b_pos,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [gatb_pkg::CHR_W-1:0]             m_child_a,
    output logic [gatb_pkg::CHR_W-1:0]             m_child_b,
    output logic [gatb_pkg::SLOT_W-1:0]            m_winner_a,
    output logic [gatb_pkg::SLOT_W-1:0]            m_winner_b,
    output logic [gatb_pkg::SLOT_W-1:0]            m_elite_first,
    output logic [gatb_pkg::SLOT_W-1:0]            m_elite_second,
    output logic signed [gatb_pkg::RATING_W-1:0]   m_elite_rating
);
    import gatb_pkg::*;

    store_req_t                 req;
    logic [GENE_BITS-1:0]       wr_chromosome;
    logic [GENE_BITS-1:0]       chr_q;
    logic signed [RATING_W-1:0] rat_q;

    gatb_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .GENE_BITS (GENE_BITS)
    ) u_store (
        .aclk          (aclk),
        .req           (req),
        .wr_chromosome (wr_chromosome),
        .chr_q         (chr_q),
        .rat_q         (rat_q)
    );

    gatb_ctrl #(
        .NUM_SLOTS  (NUM_SLOTS),
        .GENE_BITS  (GENE_BITS),
        .TOURNAMENT (TOURNAMENT)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_slot         (s_slot),
        .s_chromosome   (s_chromosome),
        .s_rating       (s_rating),
        .s_draws_a      (s_draws_a),
        .s_draws_b      (s_draws_b),
        .s_do_cross     (s_do_cross),
        .s_cross_point  (s_cross_point),
        .s_mutate_a     (s_mutate_a),
        .s_mutate_a_pos (s_mutate_a_pos),
        .s_mutate_b     (s_mutate_b),
        .s_mutate_b_pos (s_mutate_b_pos),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_child_a      (m_child_a),
        .m_child_b      (m_child_b),
        .m_winner_a     (m_winner_a),
        .m_winner_b     (m_winner_b),
        .m_elite_first  (m_elite_first),
        .m_elite_second (m_elite_second),
        .m_elite_rating (m_elite_rating),
        .req            (req),
        .wr_chromosome  (wr_chromosome),
        .chr_q          (chr_q),
        .rat_q          (rat_q)
    );

endmodule

[sv/gatb_store.sv]
// ----------------------------------------------------------------------------
// gatb_store
// Population store: chromosome and rating memories, one write port and one
// registered read port each.
// ----------------------------------------------------------------------------
module gatb_store #(
    parameter int NUM_SLOTS = gatb_pkg::NUM_SLOTS_DEF,
    parameter int GENE_BITS = gatb_pkg::GENE_BITS_DEF
) (
    input  logic                                   aclk,
    input  gatb_pkg::store_req_t                   req,
    input  logic [GENE_BITS-1:0]                   wr_chromosome,
    output logic [GENE_BITS-1:0]                   chr_q,
    output logic signed [gatb_pkg::RATING_W-1:0]   rat_q
);
    import gatb_pkg::*;

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [GENE_BITS-1:0]        chr_mem [NUM_SLOTS];
    logic signed [RATING_W-1:0]  rat_mem [NUM_SLOTS];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            chr_mem[req.wr_addr[AW-1:0]] <= wr_chromosome;
            rat_mem[req.wr_addr[AW-1:0]] <= req.wr_rating;
        end
        chr_q <= chr_mem[req.chr_rd_addr[AW-1:0]];
        rat_q <= rat_mem[req.rat_rd_addr[AW-1:0]];
    end

endmodule

[sv/gatb_mix.sv]
// ----------------------------------------------------------------------------
// gatb_mix
// Crossover and mutation: when do_cross is set, swaps the bits below the
// crossover point between the two parents; flips one bit in each selected child.
// ----------------------------------------------------------------------------
module gatb_mix #(
    parameter int GENE_BITS = gatb_pkg::GENE_BITS_DEF
) (
    input  logic [GENE_BITS-1:0]           parent_a,
    input  logic [GENE_BITS-1:0]           parent_b,
    input  logic                           do_cross,
    input  logic [gatb_pkg::POS_W-1:0]     cross_point,
    input  logic                           mutate_a,
    input  logic [gatb_pkg::POS_W-1:0]     mutate_a_pos,
    input  logic                           mutate_b,
    input  logic [gatb_pkg::POS_W-1:0]     mutate_b_pos,
    output logic [GENE_BITS-1:0]           child_a,
    output logic [GENE_BITS-1:0]           child_b
);
    import gatb_pkg::*;

    localparam logic [POS_W-1:0] PT_MAX  = POS_W'(GENE_BITS - 2);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(GENE_BITS - 1);

    logic [POS_W-1:0]      pt;
    logic [POS_W-1:0]      pa;
    logic [POS_W-1:0]      pb;
    logic [GENE_BITS-1:0]  low_mask;
    logic [GENE_BITS-1:0]  xa;
    logic [GENE_BITS-1:0]  xb;

    always_comb begin
        pt = (cross_point > PT_MAX) ? PT_MAX : cross_point;
        pa = (mutate_a_pos > POS_MAX) ? POS_MAX : mutate_a_pos;
        pb = (mutate_b_pos > POS_MAX) ? POS_MAX : mutate_b_pos;
        low_mask = (GENE_BITS'(1) << pt) - GENE_BITS'(1);
        if (do_cross) begin
            xa = (parent_a & ~low_mask) | (parent_b & low_mask);
            xb = (parent_b & ~low_mask) | (parent_a & low_mask);
        end else begin
            xa = parent_a;
            xb = parent_b;
        end
        child_a = mutate_a ? (xa ^ (GENE_BITS'(1) << pa)) : xa;
        child_b = mutate_b ? (xb ^ (GENE_BITS'(1) << pb)) : xb;
    end

endmodule

[sv/gatb_ctrl.sv]
// ----------------------------------------------------------------------------
// gatb_ctrl
// Sequencer of the breeder: walks loads, reads and breeds through the store's
// read ports, comparing ratings as they are read, keeps the elite list and
// holds the result item until it is taken.
// ----------------------------------------------------------------------------
module gatb_ctrl #(
    parameter int NUM_SLOTS  = gatb_pkg::NUM_SLOTS_DEF,
    parameter int GENE_BITS  = gatb_pkg::GENE_BITS_DEF,
    parameter int TOURNAMENT = gatb_pkg::TOURNAMENT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [gatb_pkg::MODE_W-1:0]            s_mode,
    input  logic [gatb_pkg::SLOT_W-1:0]            s_slot,
    input  logic [gatb_pkg::CHR_W-1:0]             s_chromosome,
    input  logic signed [gatb_pkg::RATING_W-1:0]   s_rating,
    input  logic [gatb_pkg::DRAWS_W-1:0]           s_draws_a,
    input  logic [gatb_pkg::DRAWS_W-1:0]           s_draws_b,
    input  logic                                   s_do_cross,
    input  logic [gatb_pkg::POS_W-1:0]             s_cross_point,
    input  logic                                   s_mutate_a,
    input  logic [gatb_pkg::POS_W-1:0]             s_mutate_a_pos,
    input  logic                                   s_mutate_b,
    input  logic [gatb_pkg::POS_W-1:0]             s_mutate_b_pos,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [gatb_pkg::CHR_W-1:0]             m_child_a,
    output logic [gatb_pkg::CHR_W-1:0]             m_child_b,
    output logic [gatb_pkg::SLOT_W-1:0]            m_winner_a,
    output logic [gatb_pkg::SLOT_W-1:0]            m_winner_b,
    output logic [gatb_pkg::SLOT_W-1:0]            m_elite_first,
    output logic [gatb_pkg::SLOT_W-1:0]            m_elite_second,
    output logic signed [gatb_pkg::RATING_W-1:0]   m_elite_rating,
    output gatb_pkg::store_req_t                   req,
    output logic [GENE_BITS-1:0]                   wr_chromosome,
    input  logic [GENE_BITS-1:0]                   chr_q,
    input  logic signed [gatb_pkg::RATING_W-1:0]   rat_q
);
    import gatb_pkg::*;

    localparam logic [SLOT_W:0]   POP_LIM = (SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] IDX_MAX = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [1:0]        K_LAST  = 2'(TOURNAMENT - 1);

    state_t                      state_reg, state_next;
    logic                        m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]           best_reg, best_next;
    logic [SLOT_W-1:0]           runner_reg, runner_next;
    logic                        par_reg, par_next;
    logic [1:0]                  k_reg, k_next;

    logic [MODE_W-1:0]           mode_reg, mode_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [GENE_BITS-1:0]        chr_in_reg, chr_in_next;
    logic signed [RATING_W-1:0]  rating_in_reg, rating_in_next;
    logic [DRAWS_W-1:0]          draws_a_reg, draws_a_next;
    logic [DRAWS_W-1:0]          draws_b_reg, draws_b_next;
    logic                        do_cross_reg, do_cross_next;
    logic [POS_W-1:0]            cross_point_reg, cross_point_next;
    logic                        mut_a_reg, mut_a_next;
    logic [POS_W-1:0]            mut_a_pos_reg, mut_a_pos_next;
    logic                        mut_b_reg, mut_b_next;
    logic [POS_W-1:0]            mut_b_pos_reg, mut_b_pos_next;
    logic                        gt_reg, gt_next;
    logic signed [RATING_W-1:0]  win_rat_reg, win_rat_next;
    logic [SLOT_W-1:0]           win_a_reg, win_a_next;
    logic [SLOT_W-1:0]           win_b_reg, win_b_next;
    logic [GENE_BITS-1:0]        ca_reg, ca_next;
    logic [GENE_BITS-1:0]        cb_reg, cb_next;
    logic signed [RATING_W-1:0]  elite_rat_reg, elite_rat_next;

    logic [CHR_W-1:0]            out_a_reg, out_a_next;
    logic [CHR_W-1:0]            out_b_reg, out_b_next;
    logic [SLOT_W-1:0]           out_wa_reg, out_wa_next;
    logic [SLOT_W-1:0]           out_wb_reg, out_wb_next;
    logic [SLOT_W-1:0]           out_ef_reg, out_ef_next;
    logic [SLOT_W-1:0]           out_es_reg, out_es_next;
    logic signed [RATING_W-1:0]  out_er_reg, out_er_next;

    logic [GENE_BITS-1:0]        mix_a;
    logic [GENE_BITS-1:0]        mix_b;
    logic [SLOT_W-1:0]           cand;
    logic                        nxt_par;
    logic [1:0]                  nxt_k;
    logic                        slot_ok;

    function automatic logic [SLOT_W-1:0] draw_pick(input logic [DRAWS_W-1:0] d,
                                                    input logic [1:0] k);
        logic [SLOT_W-1:0] b;
        case (k)
            2'd0:    b = d[7:0];
            2'd1:    b = d[15:8];
            default: b = d[23:16];
        endcase
        return ({1'b0, b} >= POP_LIM) ? IDX_MAX : b;
    endfunction

    gatb_mix #(
        .GENE_BITS (GENE_BITS)
    ) u_mix (
        .parent_a     (ca_reg),
        .parent_b     (cb_reg),
        .do_cross     (do_cross_reg),
        .cross_point  (cross_point_reg),
        .mutate_a     (mut_a_reg),
        .mutate_a_pos (mut_a_pos_reg),
        .mutate_b     (mut_b_reg),
        .mutate_b_pos (mut_b_pos_reg),
        .child_a      (mix_a),
        .child_b      (mix_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            best_reg    <= '0;
            runner_reg  <= '0;
            par_reg     <= 1'b0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            best_reg    <= best_next;
            runner_reg  <= runner_next;
            par_reg     <= par_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        slot_reg        <= slot_next;
        chr_in_reg      <= chr_in_next;
        rating_in_reg   <= rating_in_next;
        draws_a_reg     <= draws_a_next;
        draws_b_reg     <= draws_b_next;
        do_cross_reg    <= do_cross_next;
        cross_point_reg <= cross_point_next;
        mut_a_reg       <= mut_a_next;
        mut_a_pos_reg   <= mut_a_pos_next;
        mut_b_reg       <= mut_b_next;
        mut_b_pos_reg   <= mut_b_pos_next;
        gt_reg          <= gt_next;
        win_rat_reg     <= win_rat_next;
        win_a_reg       <= win_a_next;
        win_b_reg       <= win_b_next;
        ca_reg          <= ca_next;
        cb_reg          <= cb_next;
        elite_rat_reg   <= elite_rat_next;
        out_a_reg       <= out_a_next;
        out_b_reg       <= out_b_next;
        out_wa_reg      <= out_wa_next;
        out_wb_reg      <= out_wb_next;
        out_ef_reg      <= out_ef_next;
        out_es_reg      <= out_es_next;
        out_er_reg      <= out_er_next;
    end

    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        best_next        = best_reg;
        runner_next      = runner_reg;
        par_next         = par_reg;
        k_next           = k_reg;
        mode_next        = mode_reg;
        slot_next        = slot_reg;
        chr_in_next      = chr_in_reg;
        rating_in_next   = rating_in_reg;
        draws_a_next     = draws_a_reg;
        draws_b_next     = draws_b_reg;
        do_cross_next    = do_cross_reg;
        cross_point_next = cross_point_reg;
        mut_a_next       = mut_a_reg;
        mut_a_pos_next   = mut_a_pos_reg;
        mut_b_next       = mut_b_reg;
        mut_b_pos_next   = mut_b_pos_reg;
        gt_next          = gt_reg;
        win_rat_next     = win_rat_reg;
        win_a_next       = win_a_reg;
        win_b_next       = win_b_reg;
        ca_next          = ca_reg;
        cb_next          = cb_reg;
        elite_rat_next   = elite_rat_reg;
        out_a_next       = out_a_reg;
        out_b_next       = out_b_reg;
        out_wa_next      = out_wa_reg;
        out_wb_next      = out_wb_reg;
        out_ef_next      = out_ef_reg;
        out_es_next      = out_es_reg;
        out_er_next      = out_er_reg;

        req.wr_en       = 1'b0;
        req.wr_addr     = slot_reg;
        req.wr_rating   = rating_in_reg;
        req.chr_rd_addr = slot_reg;
        req.rat_rd_addr = best_reg;

        s_ready = (state_reg == ST_IDLE);
        slot_ok = ({1'b0, s_slot} < POP_LIM);
        cand    = draw_pick(par_reg ? draws_b_reg : draws_a_reg, k_reg);
        if (k_reg == K_LAST) begin
            nxt_par = 1'b1;
            nxt_k   = '0;
        end else begin
            nxt_par = par_reg;
            nxt_k   = k_reg + 2'd1;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next        = s_mode;
                    slot_next        = s_slot;
                    chr_in_next      = s_chromosome[GENE_BITS-1:0];
                    rating_in_next   = s_rating;
                    draws_a_next     = s_draws_a;
                    draws_b_next     = s_draws_b;
                    do_cross_next    = s_do_cross;
                    cross_point_next = s_cross_point;
                    mut_a_next       = s_mutate_a;
                    mut_a_pos_next   = s_mutate_a_pos;
                    mut_b_next       = s_mutate_b;
                    mut_b_pos_next   = s_mutate_b_pos;
                    par_next         = 1'b0;
                    k_next           = '0;
                    case (s_mode)
                        MODE_LOAD:  state_next = slot_ok ? ST_LD_WR : ST_FIN_A;
                        MODE_READ:  state_next = ST_RD;
                        MODE_BREED: state_next = ST_BR_ISS;
                        default:    state_next = ST_FIN_A;
                    endcase
                end
            end
            ST_LD_WR: begin
                req.wr_en = 1'b1;
                if (slot_reg == '0) begin
                    best_next   = '0;
                    runner_next = '0;
                end
                state_next = ST_LD_A1;
            end
            ST_LD_A1: begin
                req.rat_rd_addr = runner_reg;
                state_next      = ST_LD_C1;
            end
            ST_LD_C1: begin
                req.rat_rd_addr = best_reg;
                gt_next         = rating_in_reg > rat_q;
                state_next      = ST_LD_C2;
            end
            ST_LD_C2: begin
                if (gt_reg) begin
                    if (rating_in_reg > rat_q) begin
                        runner_next = best_reg;
                        best_next   = slot_reg;
                    end else begin
                        runner_next = slot_reg;
                    end
                end
                state_next = ST_FIN_A;
            end
            ST_RD: begin
                req.chr_rd_addr = slot_reg;
                req.rat_rd_addr = best_reg;
                state_next      = ST_RD_C;
            end
            ST_RD_C: begin
                ca_next        = ({1'b0, slot_reg} < POP_LIM) ? chr_q : '0;
                elite_rat_next = rat_q;
                state_next     = ST_OUT;
            end
            ST_BR_ISS: begin
                req.rat_rd_addr = cand;
                state_next      = ST_BR_CMP;
            end
            ST_BR_CMP: begin
                if (k_reg == '0 || rat_q > win_rat_reg) begin
                    win_rat_next = rat_q;
                    if (par_reg) begin
                        win_b_next = cand;
                    end else begin
                        win_a_next = cand;
                    end
                end
                req.rat_rd_addr = draw_pick(nxt_par ? draws_b_reg : draws_a_reg, nxt_k);
                req.chr_rd_addr = win_a_reg;
                par_next        = nxt_par;
                k_next          = nxt_k;
                if (par_reg && k_reg == K_LAST) begin
                    state_next = ST_BR_CHA;
                end
            end
            ST_BR_CHA: begin
                ca_next         = chr_q;
                req.chr_rd_addr = win_b_reg;
                req.rat_rd_addr = best_reg;
                state_next      = ST_BR_CHB;
            end
            ST_BR_CHB: begin
                cb_next        = chr_q;
                elite_rat_next = rat_q;
                state_next     = ST_OUT;
            end
            ST_FIN_A: begin
                req.rat_rd_addr = best_reg;
                state_next      = ST_FIN_C;
            end
            ST_FIN_C: begin
                elite_rat_next = rat_q;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_a_next   = '0;
                    out_b_next   = '0;
                    out_wa_next  = '0;
                    out_wb_next  = '0;
                    case (mode_reg)
                        MODE_READ: begin
                            out_a_next = CHR_W'(ca_reg);
                        end
                        MODE_BREED: begin
                            out_a_next  = CHR_W'(mix_a);
                            out_b_next  = CHR_W'(mix_b);
                            out_wa_next = win_a_reg;
                            out_wb_next = win_b_reg;
                        end
                        default: begin
                        end
                    endcase
                    out_ef_next  = best_reg;
                    out_es_next  = runner_reg;
                    out_er_next  = elite_rat_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign wr_chromosome  = chr_in_reg;
    assign m_valid        = m_valid_reg;
    assign m_child_a      = out_a_reg;
    assign m_child_b      = out_b_reg;
    assign m_winner_a     = out_wa_reg;
    assign m_winner_b     = out_wb_reg;
    assign m_elite_first  = out_ef_reg;
    assign m_elite_second = out_es_reg;
    assign m_elite_rating = out_er_reg;

endmodule
